@@ design/lht_pkg.sv @@
`default_nettype none
package lht_pkg;
   localparam int MAX_BUCKETS = 64;
   localparam int ENTRIES     = 256;
   localparam int KEY_BITS    = 32;
   localparam int EW = $clog2(ENTRIES);
   localparam int LW = EW + 1;
   localparam int BW = $clog2(MAX_BUCKETS);
   localparam logic [LW-1:0] NIL = LW'(ENTRIES);

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;

   localparam logic [1:0] ST_SUCCESS = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [0:0] CSR_SPLIT_THRESHOLD = 1'd0;

   typedef enum logic [3:0] {
      S_IDLE, S_BUCKET, S_HEAD, S_WALK, S_DECIDE, S_FREE, S_SPLIT_READ, S_SPLIT_HEAD,
      S_SPLIT_WALK, S_SPLIT_DONE, S_SPLIT_NEW, S_RESPOND
   } state_type;
endpackage
`default_nettype wire

@@ design/linear_hashing_table.sv @@
`default_nettype none
// Linear-hashing key set.
// Issue a request by raising start with req_type, req_key and req_key_hash
// while busy is low; the beat is taken at that edge and busy rises at once.
// req_type: insert, remove, lookup (code 3 acts as lookup).
// One result beat follows per request: rsp_valid is high for exactly one
// cycle with rsp_ok, rsp_status, rsp_element_count and rsp_bucket. The
// receiver cannot stall, so the result is simply dropped onto the ports.
// Each request reads its bucket, then walks its chain one entry at a time,
// each hop being one registered read of the entry memory; an insert that
// splits then walks and redistributes the chain of the bucket at the split
// pointer. busy drops the cycle after the result beat, so a new request is
// taken only once the previous one has given its result.
// Reset clears all control state; bucket heads and fills use valid bits,
// the free stack starts full via a low-water mark (no clearing pass needed).
// The csr port holds split_threshold at address 0; write only while idle.
module linear_hashing_table
   import lht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_key_hash,
   output logic             rsp_valid,
   output logic             rsp_ok,
   output logic [1:0]       rsp_status,
   output logic [8:0]       rsp_element_count,
   output logic [5:0]       rsp_bucket,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   // entry memory: key, hash, link
   logic [KEY_BITS-1:0] key_mem [ENTRIES];
   logic [31:0]         hash_mem [ENTRIES];
   logic [LW-1:0]       link_mem [ENTRIES];
   logic [EW-1:0]       free_mem [ENTRIES];
   // bucket table: {fill, head} per bucket; a clear valid bit reads as empty
   logic [2*LW-1:0] bkt_mem [MAX_BUCKETS];
   logic [MAX_BUCKETS-1:0] bvalid_ff;

   state_type state_ff, state_in;
   logic [3:0] thr_ff;
   logic [1:0] op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [31:0] hash_ff;
   logic [BW-1:0] b_ff;
   logic [LW-1:0] cur_ff, prev_ff;
   logic [LW-1:0] guard_ff;
   logic [LW-1:0] free_top_ff;
   logic [LW-1:0] init_ff; // lowest slot ever popped; slots below hold their own index
   logic [BW:0] biu_ff;
   logic [BW-1:0] sp_ff;
   logic [2:0] lvl_ff;
   logic [8:0] count_ff;
   logic found_ff;
   logic ok_ff;
   logic [1:0] st_ff;
   // bucket of the request, as read at the start
   logic [LW-1:0] bhead_ff, bfill_ff;
   // split walk
   logic [LW-1:0] kh_ff, kt_ff, mh_ff, mt_ff, kn_ff, mn_ff;
   logic [BW-1:0] ob_ff, nb_ff;
   // registered memory reads
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [31:0] rd_hash_ff;
   logic [LW-1:0] rd_link_ff;
   logic [EW-1:0] rd_free_ff;
   logic [2*LW-1:0] rd_bkt_ff;
   logic rd_bvalid_ff;
   logic [EW-1:0] rd_addr;
   logic [EW-1:0] fr_addr;
   logic [BW-1:0] bk_addr;
   logic [BW-1:0] req_b;

   function automatic logic [BW-1:0] map_b(input logic [31:0] h, input logic [2:0] lv,
                                            input logic [BW-1:0] sp);
      logic [31:0] lo, hi, b;
      lo = (32'd1 << lv) - 32'd1;
      hi = (32'd1 << (lv + 3'd1)) - 32'd1;
      b = h & lo;
      if (b < 32'(sp)) b = h & hi;
      if (b >= 32'(MAX_BUCKETS)) b = 32'(MAX_BUCKETS - 1);
      return b[BW-1:0];
   endfunction

   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_SPLIT_THRESHOLD) ? {28'd0, thr_ff} : 32'd0;
   assign busy = (state_ff != S_IDLE);

   logic [LW-1:0] bk_head, bk_fill;
   assign bk_head = rd_bvalid_ff ? rd_bkt_ff[LW-1:0] : NIL;
   assign bk_fill = rd_bvalid_ff ? rd_bkt_ff[2*LW-1:LW] : '0;
   logic [LW-1:0] free_val; // value popped from free stack
   assign free_val = (free_top_ff - LW'(1) < init_ff) ? (free_top_ff - LW'(1))
                                                     : {1'b0, rd_free_ff};
   assign fr_addr = EW'(free_top_ff - LW'(1));
   assign req_b = map_b(req_key_hash, lvl_ff, sp_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:       if (start) state_in = S_BUCKET;
         S_BUCKET:     state_in = S_HEAD;
         S_HEAD:       state_in = (cur_ff == NIL) ? S_DECIDE : S_WALK;
         S_WALK: begin
            // rd_* hold entry cur_ff
            if (rd_key_ff == key_ff) state_in = S_DECIDE;
            else if (rd_link_ff == NIL || guard_ff == LW'(ENTRIES - 1)) state_in = S_DECIDE;
            else state_in = S_HEAD;
         end
         S_DECIDE: begin
            if (op_ff == REQ_INSERT && !found_ff && free_top_ff != '0 &&
                bfill_ff + LW'(1) > LW'(thr_ff) && biu_ff < (BW+1)'(MAX_BUCKETS))
               state_in = S_SPLIT_READ;
            else state_in = S_RESPOND;
         end
         S_SPLIT_READ: state_in = S_SPLIT_HEAD;
         S_SPLIT_HEAD: state_in = (cur_ff == NIL) ? S_SPLIT_DONE : S_FREE;
         S_FREE:       state_in = S_SPLIT_WALK;
         S_SPLIT_WALK: state_in = (rd_link_ff == NIL || guard_ff == LW'(ENTRIES - 1))
                                  ? S_SPLIT_DONE : S_FREE;
         S_SPLIT_DONE: state_in = S_SPLIT_NEW;
         S_SPLIT_NEW:  state_in = S_RESPOND;
         S_RESPOND:    state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // read address: entry to be examined
   assign rd_addr = EW'(cur_ff);

   // bucket read: the request's bucket at accept, the split bucket while deciding
   always_comb begin
      case (state_ff)
         S_IDLE:   bk_addr = req_b;
         S_DECIDE: bk_addr = sp_ff;
         default:  bk_addr = b_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_key_ff    <= key_mem[rd_addr];
      rd_hash_ff   <= hash_mem[rd_addr];
      rd_link_ff   <= link_mem[rd_addr];
      rd_free_ff   <= free_mem[fr_addr];
      rd_bkt_ff    <= bkt_mem[bk_addr];
      rd_bvalid_ff <= bvalid_ff[bk_addr];
   end

   logic [BW-1:0] sb;
   assign sb = map_b(rd_hash_ff, lvl_ff, sp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         thr_ff <= 4'd4;
         bvalid_ff <= '0;
         free_top_ff <= LW'(ENTRIES);
         init_ff <= LW'(ENTRIES);
         biu_ff <= (BW+1)'(1);
         sp_ff <= '0;
         lvl_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr && csr_paddr[2] == CSR_SPLIT_THRESHOLD) thr_ff <= csr_pwdata[3:0];
         case (state_ff)
            S_IDLE: if (start) begin
               op_ff <= req_type;
               key_ff <= req_key;
               hash_ff <= req_key_hash;
               b_ff <= req_b;
               prev_ff <= NIL;
               guard_ff <= '0;
               found_ff <= 1'b0;
            end
            S_BUCKET: begin
               // bucket read issued at accept is ready
               cur_ff <= bk_head;
               bhead_ff <= bk_head;
               bfill_ff <= bk_fill;
            end
            S_HEAD: ;
            S_WALK: begin
               if (rd_key_ff == key_ff) found_ff <= 1'b1;
               else begin
                  prev_ff <= cur_ff;
                  cur_ff <= rd_link_ff;
                  guard_ff <= guard_ff + LW'(1);
               end
            end
            S_DECIDE: begin
               ok_ff <= 1'b0;
               st_ff <= ST_SUCCESS;
               if (op_ff == REQ_INSERT) begin
                  if (found_ff) st_ff <= ST_PRESENT;
                  else if (free_top_ff == '0) st_ff <= ST_FULL;
                  else begin
                     key_mem[EW'(free_val)] <= key_ff;
                     hash_mem[EW'(free_val)] <= hash_ff;
                     link_mem[EW'(free_val)] <= bhead_ff;
                     bkt_mem[b_ff] <= {bfill_ff + LW'(1), free_val};
                     bvalid_ff[b_ff] <= 1'b1;
                     if (free_top_ff - LW'(1) < init_ff) init_ff <= free_top_ff - LW'(1);
                     free_top_ff <= free_top_ff - LW'(1);
                     count_ff <= count_ff + 9'd1;
                     ok_ff <= 1'b1;
                     // prepare split
                     ob_ff <= sp_ff;
                     nb_ff <= biu_ff[BW-1:0];
                     kh_ff <= NIL; kt_ff <= NIL; mh_ff <= NIL; mt_ff <= NIL;
                     kn_ff <= '0; mn_ff <= '0;
                     guard_ff <= '0;
                     if (bfill_ff + LW'(1) > LW'(thr_ff) && biu_ff < (BW+1)'(MAX_BUCKETS)) begin
                        biu_ff <= biu_ff + (BW+1)'(1);
                        sp_ff <= sp_ff + BW'(1);
                        // head of split bucket when it is the one just inserted into
                        cur_ff <= free_val;
                     end
                  end
               end else if (op_ff == REQ_REMOVE) begin
                  if (!found_ff) st_ff <= ST_ABSENT;
                  else begin
                     if (prev_ff != NIL) link_mem[EW'(prev_ff)] <= rd_link_ff;
                     bkt_mem[b_ff] <= {(bfill_ff != '0) ? bfill_ff - LW'(1) : bfill_ff,
                                       (prev_ff == NIL) ? rd_link_ff : bhead_ff};
                     bvalid_ff[b_ff] <= 1'b1;
                     if (free_top_ff < LW'(ENTRIES)) begin
                        free_mem[EW'(free_top_ff)] <= EW'(cur_ff);
                        free_top_ff <= free_top_ff + LW'(1);
                     end
                     if (count_ff != '0) count_ff <= count_ff - 9'd1;
                     ok_ff <= 1'b1;
                  end
               end else begin
                  if (!found_ff) st_ff <= ST_ABSENT;
                  else ok_ff <= 1'b1;
               end
            end
            S_SPLIT_READ: begin
               // split bucket read was issued while deciding
               if (b_ff != ob_ff) cur_ff <= bk_head;
            end
            S_SPLIT_HEAD: ;
            S_FREE: ;
            S_SPLIT_WALK: begin
               // split map uses updated sp; moved if != ob
               if (sb != ob_ff) begin
                  if (mt_ff == NIL) mh_ff <= cur_ff;
                  else link_mem[EW'(mt_ff)] <= cur_ff;
                  mt_ff <= cur_ff;
                  mn_ff <= mn_ff + LW'(1);
               end else begin
                  if (kt_ff == NIL) kh_ff <= cur_ff;
                  else link_mem[EW'(kt_ff)] <= cur_ff;
                  kt_ff <= cur_ff;
                  kn_ff <= kn_ff + LW'(1);
               end
               cur_ff <= rd_link_ff;
               guard_ff <= guard_ff + LW'(1);
            end
            S_SPLIT_DONE: begin
               // close the kept chain and store the old bucket
               if (kt_ff != NIL) link_mem[EW'(kt_ff)] <= NIL;
               bkt_mem[ob_ff] <= {kn_ff, kh_ff};
               bvalid_ff[ob_ff] <= 1'b1;
            end
            S_SPLIT_NEW: begin
               // close the moved chain, store the new bucket, advance the round
               if (mt_ff != NIL) link_mem[EW'(mt_ff)] <= NIL;
               bkt_mem[nb_ff] <= {mn_ff, mh_ff};
               bvalid_ff[nb_ff] <= 1'b1;
               if ((32'd1 << (lvl_ff + 3'd1)) <= 32'(biu_ff)) begin
                  lvl_ff <= lvl_ff + 3'd1;
                  sp_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = (state_ff == S_RESPOND);
   assign rsp_ok = ok_ff;
   assign rsp_status = st_ff;
   assign rsp_element_count = count_ff;
   assign rsp_bucket = b_ff;

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat longer than one cycle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted request did not raise busy");
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_status == ST_SUCCESS) else $error("ok with failure status");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 9'(ENTRIES)) else $error("count exceeds pool");
endmodule
`default_nettype wire

@@ verif/tb_linear_hashing_table.sv @@
module tb_linear_hashing_table;
   import lht_pkg::*;

   // Lookup has no package name; code 3 is the unused code, served as a lookup.
   localparam logic [1:0] REQ_LOOKUP = 2'd2;
   localparam logic [1:0] REQ_SPARE  = 2'd3;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int DRAIN_CYCLES = 1200;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_type;
   logic [31:0] req_key;
   logic [31:0] req_key_hash;
   logic        rsp_valid;
   logic        rsp_ok;
   logic [1:0]  rsp_status;
   logic [8:0]  rsp_element_count;
   logic [5:0]  rsp_bucket;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   linear_hashing_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_key(req_key), .req_key_hash(req_key_hash),
      .rsp_valid(rsp_valid), .rsp_ok(rsp_ok), .rsp_status(rsp_status),
      .rsp_element_count(rsp_element_count), .rsp_bucket(rsp_bucket),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // One expected response beat.
   typedef struct {
      logic       ok;
      logic [1:0] status;
      logic [8:0] count;
      logic [5:0] bucket;
   } outcome_type;

   // One row of the directed table; pinned rows carry a typed-in outcome.
   typedef struct {
      logic [1:0]  kind;
      logic [31:0] key;
      logic [31:0] hash;
      bit          pinned;
      outcome_type want;
   } req_row_type;

   // A key the mirror table holds, with the hash it was filed under.
   typedef struct {
      logic [31:0] key;
      logic [31:0] hash;
   } held_key_type;

   outcome_type  pending_rsp[$];
   held_key_type held_keys[$];
   bit        failed;
   int        cycles;

   // Mirror of the table.
   logic [31:0] mk_key[ENTRIES];
   logic [31:0] mk_hash[ENTRIES];
   int          mk_link[ENTRIES];
   int          mk_head[MAX_BUCKETS];
   int          mk_fill[MAX_BUCKETS];
   int          mk_free[ENTRIES];
   int          mk_free_top;
   int          mk_buckets;
   int          mk_split_ptr;
   int          mk_level;
   int          mk_count;
   int          mk_threshold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int home_bucket(logic [31:0] h);
      int b;
      b = int'(h & ((32'd1 << mk_level) - 32'd1));
      if (b < mk_split_ptr)
         b = int'(h & ((32'd1 << (mk_level + 1)) - 32'd1));
      if (b >= MAX_BUCKETS)
         b = MAX_BUCKETS - 1;
      return b;
   endfunction

   // Redistribute the bucket at the split pointer between itself and a fresh bucket.
   function automatic void split_bucket();
      int nb, ob, e, nx, kh, kt, mh, mt, kn, mn;
      nb = mk_buckets;
      ob = mk_split_ptr;
      e = mk_head[ob];
      kh = ENTRIES; kt = ENTRIES; mh = ENTRIES; mt = ENTRIES;
      kn = 0; mn = 0;
      mk_buckets++;
      mk_split_ptr++;
      while (e < ENTRIES) begin
         nx = mk_link[e];
         if (home_bucket(mk_hash[e]) != ob) begin
            if (mt == ENTRIES) mh = e; else mk_link[mt] = e;
            mt = e;
            mn++;
         end else begin
            if (kt == ENTRIES) kh = e; else mk_link[kt] = e;
            kt = e;
            kn++;
         end
         mk_link[e] = ENTRIES;
         e = nx;
      end
      mk_head[ob] = kh; mk_fill[ob] = kn;
      mk_head[nb] = mh; mk_fill[nb] = mn;
      if ((1 << (mk_level + 1)) <= mk_buckets) begin
         mk_level++;
         mk_split_ptr = 0;
      end
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < MAX_BUCKETS; i++) begin
         mk_head[i] = ENTRIES;
         mk_fill[i] = 0;
      end
      for (int i = 0; i < ENTRIES; i++) mk_free[i] = i;
      mk_free_top = ENTRIES;
      mk_buckets = 1;
      mk_split_ptr = 0;
      mk_level = 0;
      mk_count = 0;
      mk_threshold = 4;
   endfunction

   // Apply one request to the mirror and return the response it must produce.
   function automatic outcome_type apply_request(logic [1:0] kind, logic [31:0] key,
                                                 logic [31:0] h);
      outcome_type r;
      int b, e, p, n;
      b = home_bucket(h);
      e = mk_head[b];
      p = ENTRIES;
      while (e < ENTRIES && mk_key[e] != key) begin
         p = e;
         e = mk_link[e];
      end
      r.ok = 1'b0;
      r.status = ST_SUCCESS;
      r.bucket = 6'(b);
      if (kind == REQ_INSERT) begin
         if (e < ENTRIES) begin
            r.status = ST_PRESENT;
         end else if (mk_free_top == 0) begin
            r.status = ST_FULL;
         end else begin
            mk_free_top--;
            n = mk_free[mk_free_top];
            mk_key[n] = key;
            mk_hash[n] = h;
            mk_link[n] = mk_head[b];
            mk_head[b] = n;
            mk_fill[b]++;
            mk_count++;
            r.ok = 1'b1;
            held_keys.push_back('{key, h});
            if (mk_fill[b] > mk_threshold && mk_buckets < MAX_BUCKETS)
               split_bucket();
         end
      end else if (kind == REQ_REMOVE) begin
         if (e >= ENTRIES) begin
            r.status = ST_ABSENT;
         end else begin
            if (p == ENTRIES) mk_head[b] = mk_link[e];
            else mk_link[p] = mk_link[e];
            mk_fill[b]--;
            mk_free[mk_free_top++] = e;
            mk_count--;
            r.ok = 1'b1;
            foreach (held_keys[i])
               if (held_keys[i].key == key && held_keys[i].hash == h) begin
                  held_keys.delete(i);
                  break;
               end
         end
      end else begin
         if (e >= ENTRIES) r.status = ST_ABSENT;
         else r.ok = 1'b1;
      end
      r.count = 9'(mk_count);
      return r;
   endfunction

   // Hash that upstream logic would attach to a key.
   function automatic logic [31:0] mix_hash(logic [31:0] key);
      logic [31:0] x;
      x = key * 32'h9E37_79B1;
      return x ^ (x >> 15) ^ (key << 7);
   endfunction

   // Check every response beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response ok=%0b status=%0d count=%0d bucket=%0d",
                     $time, rsp_ok, rsp_status, rsp_element_count, rsp_bucket);
            failed = 1'b1;
         end else begin
            outcome_type w;
            w = pending_rsp.pop_front();
            if (rsp_ok !== w.ok) begin
               $display("%0t: ok expected %0b actual %0b", $time, w.ok, rsp_ok);
               failed = 1'b1;
            end
            if (rsp_status !== w.status) begin
               $display("%0t: status expected %0d actual %0d", $time, w.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_element_count !== w.count) begin
               $display("%0t: element_count expected %0d actual %0d",
                        $time, w.count, rsp_element_count);
               failed = 1'b1;
            end
            if (rsp_bucket !== w.bucket) begin
               $display("%0t: bucket expected %0d actual %0d", $time, w.bucket, rsp_bucket);
               failed = 1'b1;
            end
         end
      end
   end

   // Hold start until the beat is taken; predict on the accepting edge.
   task automatic issue(logic [1:0] kind, logic [31:0] key, logic [31:0] h, int gap,
                        bit pinned, outcome_type want);
      outcome_type got;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_key <= key;
      req_key_hash <= h;
      @(posedge clock);
      while (busy) @(posedge clock);
      got = apply_request(kind, key, h);
      pending_rsp.push_back(pinned ? want : got);
   endtask

   // Drain all responses, let the engine settle, then write the threshold.
   task automatic set_threshold(int value);
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {CSR_SPLIT_THRESHOLD, 2'b00};
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      mk_threshold = value;
      @(posedge clock);
   endtask

   // One random beat: mostly well-formed traffic on held keys, some noise.
   task automatic random_beat(int insert_pct, bit burst);
      int pick, gap, idx;
      logic [1:0] kind;
      logic [31:0] key, h;
      outcome_type none;
      none = '{1'b0, ST_SUCCESS, 9'd0, 6'd0};
      gap = burst ? 0 : $urandom_range(0, 18);
      pick = $urandom_range(0, 99);
      key = $urandom();
      if ($urandom_range(0, 3) == 0) key = 32'($urandom_range(0, 63));
      h = mix_hash(key);
      if (pick < insert_pct) begin
         kind = REQ_INSERT;
         if ($urandom_range(0, 9) == 0 && held_keys.size() > 0) begin
            idx = $urandom_range(0, held_keys.size() - 1);
            key = held_keys[idx].key;
            h = held_keys[idx].hash;
         end else if ($urandom_range(0, 9) == 0) begin
            h = $urandom();
         end
      end else begin
         case ($urandom_range(0, 5))
            0, 1, 2: kind = REQ_REMOVE;
            3, 4:    kind = REQ_LOOKUP;
            default: kind = REQ_SPARE;
         endcase
         if ($urandom_range(0, 4) != 0 && held_keys.size() > 0) begin
            idx = $urandom_range(0, held_keys.size() - 1);
            key = held_keys[idx].key;
            h = held_keys[idx].hash;
         end
      end
      issue(kind, key, h, gap, 1'b0, none);
   endtask

   initial begin : main
      req_row_type rows[18];
      int thresholds[6];
      int insert_mix[6];
      outcome_type none;
      bit burst;
      none = '{1'b0, ST_SUCCESS, 9'd0, 6'd0};
      failed = 1'b0;
      cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_INSERT;
      req_key = '0;
      req_key_hash = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      clear_table();

      // Pinned rows all land in bucket 0: one bucket, no split yet.
      rows[0]  = '{REQ_LOOKUP, 32'h0, 32'h0, 1, '{1'b0, ST_ABSENT, 9'd0, 6'd0}};
      rows[1]  = '{REQ_INSERT, 32'h0, 32'h0, 1, '{1'b1, ST_SUCCESS, 9'd1, 6'd0}};
      rows[2]  = '{REQ_INSERT, 32'h0, 32'h0, 1, '{1'b0, ST_PRESENT, 9'd1, 6'd0}};
      rows[3]  = '{REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                   '{1'b1, ST_SUCCESS, 9'd2, 6'd0}};
      rows[4]  = '{REQ_REMOVE, 32'h0001_2345, 32'h0, 1, '{1'b0, ST_ABSENT, 9'd2, 6'd0}};
      rows[5]  = '{REQ_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                   '{1'b1, ST_SUCCESS, 9'd2, 6'd0}};
      rows[6]  = '{REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                   '{1'b1, ST_SUCCESS, 9'd1, 6'd0}};
      rows[7]  = '{REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                   '{1'b0, ST_ABSENT, 9'd1, 6'd0}};
      // Overflow bucket 0 to force the first split, then probe both halves.
      rows[8]  = '{REQ_INSERT, 32'h1, 32'h1, 0, none};
      rows[9]  = '{REQ_INSERT, 32'h2, 32'h2, 0, none};
      rows[10] = '{REQ_INSERT, 32'h3, 32'h3, 0, none};
      rows[11] = '{REQ_INSERT, 32'h8000_0000, 32'h8000_0000, 0, none};
      rows[12] = '{REQ_INSERT, 32'h5555_AAAA, 32'hAAAA_5555, 0, none};
      rows[13] = '{REQ_LOOKUP, 32'h1, 32'h1, 0, none};
      rows[14] = '{REQ_LOOKUP, 32'h2, 32'h2, 0, none};
      rows[15] = '{REQ_REMOVE, 32'h3, 32'h3, 0, none};
      rows[16] = '{REQ_SPARE, 32'h0, 32'h0, 0, none};
      rows[17] = '{REQ_REMOVE, 32'h0, 32'h0, 0, none};

      // Threshold 0 splits on every insert; the insert-heavy phase fills the pool.
      thresholds = '{15, 1, 0, 7, 4, 10};
      insert_mix = '{60, 90, 55, 20, 50, 45};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         issue(rows[i].kind, rows[i].key, rows[i].hash, $urandom_range(0, 3),
               rows[i].pinned, rows[i].want);

      foreach (thresholds[p]) begin
         set_threshold(thresholds[p]);
         for (int n = 0; n < 315; n++) begin
            // Alternate stretches with no gaps and stretches with random gaps.
            if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            random_beat(insert_mix[p], burst);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ linear_hashing_table.f @@
design/lht_pkg.sv
design/linear_hashing_table.sv
verif/tb_linear_hashing_table.sv
